>>> sv/delta_modulation_sample_channel_assert.svh
// assertion macros shared by the delta modulation channel modules
`ifndef DELTA_MODULATION_SAMPLE_CHANNEL_ASSERT_SVH
`define DELTA_MODULATION_SAMPLE_CHANNEL_ASSERT_SVH

// same-cycle implication, sampled on aclk, quiet while in reset
`define DMSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, quiet while in reset
`define DMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dmsc_pkg.sv
// types, codes and the rate period table of the delta modulation channel
package dmsc_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_STATUS  = 2'd2;
    localparam logic [1:0] CMD_DELIVER = 2'd3;

    // register selects
    localparam logic [2:0] REG_RATE   = 3'd0;
    localparam logic [2:0] REG_LEVEL  = 3'd1;
    localparam logic [2:0] REG_ADDR   = 3'd2;
    localparam logic [2:0] REG_LENGTH = 3'd3;
    localparam logic [2:0] REG_ENABLE = 3'd4;

    localparam logic [15:0] ADDR_BASE  = 16'hC000;
    localparam logic [15:0] ADDR_WRAP  = 16'h8000;
    localparam logic [15:0] ADDR_LAST  = 16'hFFFF;
    localparam logic [8:0]  PERIOD_RESET  = 9'd428;
    localparam logic [6:0]  LEVEL_UP_MAX  = 7'd125;
    localparam logic [6:0]  LEVEL_DN_MIN  = 7'd2;
    localparam logic [6:0]  LEVEL_STEP    = 7'd2;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] fetched_byte;
    } in_item_t;

    typedef struct packed {
        logic        fetch_request;
        logic [15:0] fetch_address;
        logic [6:0]  level;
        logic        channel_active;
        logic        irq_pending;
    } out_item_t;

    function automatic logic [8:0] period_lookup(input logic [3:0] idx);
        logic [8:0] p;
        case (idx)
            4'd0:    p = 9'd428;
            4'd1:    p = 9'd380;
            4'd2:    p = 9'd340;
            4'd3:    p = 9'd320;
            4'd4:    p = 9'd286;
            4'd5:    p = 9'd254;
            4'd6:    p = 9'd226;
            4'd7:    p = 9'd214;
            4'd8:    p = 9'd190;
            4'd9:    p = 9'd160;
            4'd10:   p = 9'd142;
            4'd11:   p = 9'd128;
            4'd12:   p = 9'd106;
            4'd13:   p = 9'd84;
            4'd14:   p = 9'd72;
            default: p = 9'd54;
        endcase
        return p;
    endfunction

endpackage

>>> sv/dmsc_core.sv
// channel state registers and the next-state update for one item
`include "delta_modulation_sample_channel_assert.svh"

module dmsc_core
    import dmsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_item_t  item,
    output out_item_t result
);

    logic        enabled_reg, enabled_next;
    logic        irq_enabled_reg, irq_enabled_next;
    logic        irq_flag_reg, irq_flag_next;
    logic        loop_mode_reg, loop_mode_next;
    logic [8:0]  rate_period_reg, rate_period_next;
    logic [8:0]  rate_timer_reg, rate_timer_next;
    logic [6:0]  output_level_reg, output_level_next;
    logic [15:0] start_address_reg, start_address_next;
    logic [11:0] sample_bytes_reg, sample_bytes_next;
    logic [15:0] current_address_reg, current_address_next;
    logic [11:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  buffer_byte_reg, buffer_byte_next;
    logic        buffer_empty_reg, buffer_empty_next;
    logic [7:0]  shifter_reg, shifter_next;
    logic [3:0]  bits_left_reg, bits_left_next;
    logic        fetch_pending_reg, fetch_pending_next;
    logic        enable_bit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg         <= 1'b0;
            irq_enabled_reg     <= 1'b0;
            irq_flag_reg        <= 1'b0;
            loop_mode_reg       <= 1'b0;
            rate_period_reg     <= PERIOD_RESET;
            rate_timer_reg      <= PERIOD_RESET;
            output_level_reg    <= '0;
            start_address_reg   <= '0;
            sample_bytes_reg    <= '0;
            current_address_reg <= '0;
            bytes_left_reg      <= '0;
            buffer_byte_reg     <= '0;
            buffer_empty_reg    <= 1'b1;
            shifter_reg         <= '0;
            bits_left_reg       <= '0;
            fetch_pending_reg   <= 1'b0;
        end else begin
            enabled_reg         <= enabled_next;
            irq_enabled_reg     <= irq_enabled_next;
            irq_flag_reg        <= irq_flag_next;
            loop_mode_reg       <= loop_mode_next;
            rate_period_reg     <= rate_period_next;
            rate_timer_reg      <= rate_timer_next;
            output_level_reg    <= output_level_next;
            start_address_reg   <= start_address_next;
            sample_bytes_reg    <= sample_bytes_next;
            current_address_reg <= current_address_next;
            bytes_left_reg      <= bytes_left_next;
            buffer_byte_reg     <= buffer_byte_next;
            buffer_empty_reg    <= buffer_empty_next;
            shifter_reg         <= shifter_next;
            bits_left_reg       <= bits_left_next;
            fetch_pending_reg   <= fetch_pending_next;
        end
    end

    assign enable_bit = item.write_data[4];

    always_comb begin
        enabled_next         = enabled_reg;
        irq_enabled_next     = irq_enabled_reg;
        irq_flag_next        = irq_flag_reg;
        loop_mode_next       = loop_mode_reg;
        rate_period_next     = rate_period_reg;
        rate_timer_next      = rate_timer_reg;
        output_level_next    = output_level_reg;
        start_address_next   = start_address_reg;
        sample_bytes_next    = sample_bytes_reg;
        current_address_next = current_address_reg;
        bytes_left_next      = bytes_left_reg;
        buffer_byte_next     = buffer_byte_reg;
        buffer_empty_next    = buffer_empty_reg;
        shifter_next         = shifter_reg;
        bits_left_next       = bits_left_reg;
        fetch_pending_next   = fetch_pending_reg;
        result               = '0;

        if (fire) begin
            case (item.command)
                CMD_TICK: begin
                    if (enabled_reg) begin
                        if (rate_timer_reg != '0) begin
                            rate_timer_next = rate_timer_reg - 9'd1;
                        end else begin
                            rate_timer_next = rate_period_reg;
                            if (bits_left_reg == '0) begin
                                if (!buffer_empty_reg) begin
                                    shifter_next      = buffer_byte_reg;
                                    bits_left_next    = BITS_PER_BYTE;
                                    buffer_empty_next = 1'b1;
                                end else if (bytes_left_reg != '0 && !fetch_pending_reg) begin
                                    result.fetch_request = 1'b1;
                                    result.fetch_address = current_address_reg;
                                    fetch_pending_next   = 1'b1;
                                    bytes_left_next      = bytes_left_reg - 12'd1;
                                    current_address_next = (current_address_reg == ADDR_LAST) ?
                                        ADDR_WRAP : current_address_reg + 16'd1;
                                    // end of sample
                                    if (bytes_left_next == '0) begin
                                        if (loop_mode_reg) begin
                                            current_address_next = start_address_reg;
                                            bytes_left_next      = sample_bytes_reg;
                                        end else if (irq_enabled_reg) begin
                                            irq_flag_next = 1'b1;
                                        end
                                    end
                                end
                            end
                            // one delta step, lsb first
                            if (bits_left_next != '0) begin
                                if (shifter_next[0]) begin
                                    if (output_level_reg <= LEVEL_UP_MAX) begin
                                        output_level_next = output_level_reg + LEVEL_STEP;
                                    end
                                end else begin
                                    if (output_level_reg >= LEVEL_DN_MIN) begin
                                        output_level_next = output_level_reg - LEVEL_STEP;
                                    end
                                end
                                shifter_next   = {1'b0, shifter_next[7:1]};
                                bits_left_next = bits_left_next - 4'd1;
                            end
                        end
                    end
                end
                CMD_WRITE: begin
                    case (item.reg_select)
                        REG_RATE: begin
                            irq_enabled_next = item.write_data[7];
                            loop_mode_next   = item.write_data[6];
                            rate_period_next = period_lookup(item.write_data[3:0]);
                            rate_timer_next  = period_lookup(item.write_data[3:0]);
                            if (!item.write_data[7]) begin
                                irq_flag_next = 1'b0;
                            end
                        end
                        REG_LEVEL: begin
                            output_level_next = item.write_data[6:0];
                        end
                        REG_ADDR: begin
                            start_address_next = ADDR_BASE | {2'b00, item.write_data, 6'b000000};
                        end
                        REG_LENGTH: begin
                            sample_bytes_next = {item.write_data, 4'b0001};
                        end
                        REG_ENABLE: begin
                            if (!enabled_reg && enable_bit && bytes_left_reg == '0) begin
                                current_address_next = start_address_reg;
                                bytes_left_next      = sample_bytes_reg;
                            end
                            enabled_next = enable_bit;
                            if (!enable_bit) begin
                                bytes_left_next = '0;
                            end
                            irq_flag_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_DELIVER: begin
                    if (fetch_pending_reg) begin
                        buffer_byte_next   = item.fetched_byte;
                        buffer_empty_next  = 1'b0;
                        fetch_pending_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        result.level          = output_level_next;
        result.channel_active = (bytes_left_next != '0);
        result.irq_pending    = irq_flag_next;
    end

    `DMSC_ASSERT_NOW(a_fetch_gated, fire && result.fetch_request, !fetch_pending_reg && enabled_reg && buffer_empty_reg && bytes_left_reg != '0, "fetch requested while not allowed")
    `DMSC_ASSERT_NEXT(a_fetch_pending, fire && result.fetch_request, fetch_pending_reg && buffer_empty_reg, "fetch request not recorded as outstanding")
    `DMSC_ASSERT_NOW(a_addr_zero, !result.fetch_request, result.fetch_address == '0, "fetch address set without a request")

endmodule

>>> sv/delta_modulation_sample_channel.sv
// Delta modulation sample channel: every accepted item (tick, register write, status read or
// fetched byte delivery) gives exactly one result transfer carrying the fetch request, its
// address, the 7-bit level, the active flag and the irq flag after that item. One item is
// taken every clock cycle while the result side keeps up. The channel state is updated when
// the held item moves from the input register into the result register, at the same edge
// that loads the result register. The rate is set by the channel state update, a loop
// through the core's state registers. A full result register that is not taken stalls the
// input side after one further item is held in the input register.
`include "delta_modulation_sample_channel_assert.svh"

module delta_modulation_sample_channel
    import dmsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // input register
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;

    // result register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    out_item_t core_result;
    logic      advance;

    // the held item moves on once the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= core_result;
        end
    end

    // channel state, updated only when the held item moves into the result register
    dmsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    `DMSC_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg, "processed item did not reach the result register")
    `DMSC_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, s_ready, "input stalled with an empty result register")

endmodule

>>> tb/delta_modulation_sample_channel_tb.sv
// testbench for the delta modulation sample channel: directed table, then random playback
`timescale 1ns / 1ps

module delta_modulation_sample_channel_tb;
    import dmsc_pkg::*;

    localparam int unsigned CLK_PERIOD      = 10;
    localparam int unsigned RESET_CYCLES    = 7;
    localparam int unsigned MAX_GAP         = 13;
    // input transfers for the whole run, directed table included
    localparam int unsigned ITEM_TARGET     = 1450;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 16;
    // no transfer on either side for this long means the block has hung
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned RUN_CYCLE_CAP   = 200000;
    localparam int unsigned REPORT_LIMIT    = 10;

    // register selects the block does not decode
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    // bit positions inside the written byte
    localparam int IRQ_EN_BIT = 7;
    localparam int LOOP_BIT   = 6;
    localparam int ENABLE_BIT = 4;

    localparam logic [8:0] RATE_PERIODS [16] = '{
        9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
        9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd84,  9'd72,  9'd54
    };

    // status words that can be read off without working anything out
    localparam out_item_t IDLE_STATUS = '0;
    localparam out_item_t TOP_LEVEL_STATUS = '{fetch_request: 1'b0, fetch_address: 16'h0000,
                                               level: 7'h7F, channel_active: 1'b0,
                                               irq_pending: 1'b0};

    typedef struct {
        in_item_t    item;
        int unsigned repeats;
        bit          typed;
        out_item_t   want;
    } directed_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    delta_modulation_sample_channel dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // shadow copy of the channel state, at reset values
    logic        ch_enabled    = 1'b0;
    logic        ch_irq_en     = 1'b0;
    logic        ch_irq_flag   = 1'b0;
    logic        ch_loop       = 1'b0;
    logic [8:0]  ch_period     = PERIOD_RESET;
    logic [8:0]  ch_timer      = PERIOD_RESET;
    logic [6:0]  ch_level      = '0;
    logic [15:0] ch_start      = '0;
    logic [11:0] ch_length     = '0;
    logic [15:0] ch_addr       = '0;
    logic [11:0] ch_remaining  = '0;
    logic [7:0]  ch_buf        = '0;
    logic        ch_buf_empty  = 1'b1;
    logic [7:0]  ch_shift      = '0;
    logic [3:0]  ch_bits       = '0;
    logic        ch_fetch_wait = 1'b0;

    out_item_t   pending_status [$];
    directed_row_t directed_rows [$];

    // shared between the sender and the receiver
    bit          no_idle = 1'b0;
    bit          hold_off_pending = 1'b0;

    int unsigned items_sent = 0;
    int unsigned events_done = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned fetches_seen = 0;
    int unsigned limit_holds = 0;
    int unsigned deliver_in = 0;
    int unsigned cycle_count = 0;
    int unsigned quiet_cycles = 0;
    bit          wrapped = 1'b0;

    // advance the shadow state by one item and return the status word it leaves
    function automatic out_item_t advance_channel(input in_item_t it);
        out_item_t res;
        res = '0;
        case (it.command)
            CMD_TICK: begin
                if (ch_enabled) begin
                    if (ch_timer != 0) begin
                        ch_timer = ch_timer - 1'b1;
                    end else begin
                        ch_timer = ch_period;
                        if (ch_bits == 0) begin
                            if (!ch_buf_empty) begin
                                ch_shift     = ch_buf;
                                ch_bits      = BITS_PER_BYTE;
                                ch_buf_empty = 1'b1;
                            end else if (ch_remaining != 0 && !ch_fetch_wait) begin
                                res.fetch_request = 1'b1;
                                res.fetch_address = ch_addr;
                                ch_fetch_wait     = 1'b1;
                                ch_remaining      = ch_remaining - 1'b1;
                                ch_addr = (ch_addr == ADDR_LAST) ? ADDR_WRAP : ch_addr + 16'd1;
                                // end of sample: restart when looping, else flag it
                                if (ch_remaining == 0) begin
                                    if (ch_loop) begin
                                        ch_addr      = ch_start;
                                        ch_remaining = ch_length;
                                    end else if (ch_irq_en) begin
                                        ch_irq_flag = 1'b1;
                                    end
                                end
                            end
                        end
                        if (ch_bits != 0) begin
                            if (ch_shift[0]) begin
                                if (ch_level <= LEVEL_UP_MAX) ch_level = ch_level + LEVEL_STEP;
                                else limit_holds++;
                            end else begin
                                if (ch_level >= LEVEL_DN_MIN) ch_level = ch_level - LEVEL_STEP;
                                else limit_holds++;
                            end
                            ch_shift = ch_shift >> 1;
                            ch_bits  = ch_bits - 1'b1;
                        end
                    end
                end
            end
            CMD_WRITE: begin
                case (it.reg_select)
                    REG_RATE: begin
                        ch_irq_en = it.write_data[IRQ_EN_BIT];
                        ch_loop   = it.write_data[LOOP_BIT];
                        ch_period = RATE_PERIODS[it.write_data[3:0]];
                        ch_timer  = ch_period;
                        if (!ch_irq_en) ch_irq_flag = 1'b0;
                    end
                    REG_LEVEL:  ch_level = it.write_data[6:0];
                    REG_ADDR:   ch_start = ADDR_BASE | {2'b00, it.write_data, 6'b000000};
                    REG_LENGTH: ch_length = {it.write_data, 4'h1};
                    REG_ENABLE: begin
                        // switching on with nothing left restarts the sample
                        if (!ch_enabled && it.write_data[ENABLE_BIT] && ch_remaining == 0) begin
                            ch_addr      = ch_start;
                            ch_remaining = ch_length;
                        end
                        ch_enabled = it.write_data[ENABLE_BIT];
                        if (!ch_enabled) ch_remaining = '0;
                        ch_irq_flag = 1'b0;
                    end
                    default: ;
                endcase
            end
            CMD_DELIVER: begin
                // a byte nobody asked for is dropped
                if (ch_fetch_wait) begin
                    ch_buf        = it.fetched_byte;
                    ch_buf_empty  = 1'b0;
                    ch_fetch_wait = 1'b0;
                end
            end
            default: ;
        endcase
        res.level          = ch_level;
        res.channel_active = (ch_remaining != 0);
        res.irq_pending    = ch_irq_flag;
        return res;
    endfunction

    function automatic in_item_t mk(input logic [1:0] cmd, input logic [2:0] sel,
                                    input logic [7:0] wd, input logic [7:0] fb);
        in_item_t it;
        it.command      = cmd;
        it.reg_select   = sel;
        it.write_data   = wd;
        it.fetched_byte = fb;
        return it;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // bytes biased towards the level extremes and all-ones/all-zeros
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7E;
            3:       return 8'h01;
            default: return rand_byte();
        endcase
    endfunction

    // idle-heavy phases keep to the short periods so they stay affordable
    function automatic logic [3:0] pick_rate_index(input bit fast);
        if (fast && $urandom_range(0, 3) == 0) return 4'($urandom);
        return 4'($urandom_range(12, 15));
    endfunction

    // one input transfer: optional gap, hold valid until accepted, then predict
    task automatic offer_item(input in_item_t it, input bit typed = 1'b0,
                              input out_item_t want = '0);
        int unsigned gap;
        out_item_t got;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        // countdown-only ticks and ignored items do not count as events
        if ((it.command == CMD_TICK && ch_enabled && ch_timer == 0)
                || it.command == CMD_STATUS
                || (it.command == CMD_WRITE && it.reg_select <= REG_ENABLE)
                || (it.command == CMD_DELIVER && ch_fetch_wait))
            events_done++;
        got = advance_channel(it);
        if (got.fetch_request) begin
            fetches_seen++;
            if (got.fetch_address == ADDR_WRAP) wrapped = 1'b1;
            // memory answers quickly most of the time, sometimes late
            deliver_in = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * ch_period)
                                                       : $urandom_range(0, 4);
        end
        pending_status.push_back(typed ? want : got);
        items_sent++;
    endtask

    task automatic random_write(input bit fast);
        logic [2:0] sel;
        logic [7:0] wd;
        sel = 3'($urandom);
        wd  = pick_byte();
        if (sel == REG_RATE) wd[3:0] = pick_rate_index(fast);
        offer_item(mk(CMD_WRITE, sel, wd, rand_byte()));
    endtask

    // ticks with a responsive memory, sprinkled with reads, stray bytes and writes
    task automatic play_back(input int unsigned expiries);
        int unsigned seen;
        int unsigned r;
        seen = 0;
        while (seen < expiries && ch_enabled && items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 999);
            if (ch_fetch_wait && deliver_in == 0) begin
                offer_item(mk(CMD_DELIVER, 3'($urandom), rand_byte(), pick_byte()));
            end else if (r < 10) begin
                offer_item(mk(CMD_STATUS, 3'($urandom), rand_byte(), rand_byte()));
            end else if (r < 15) begin
                offer_item(mk(CMD_DELIVER, 3'($urandom), rand_byte(), pick_byte()));
            end else if (r < 18) begin
                random_write(no_idle);
            end else begin
                if (ch_timer == 0) seen++;
                if (deliver_in != 0) deliver_in--;
                offer_item(mk(CMD_TICK, 3'($urandom), rand_byte(), rand_byte()));
            end
        end
    endtask

    task automatic play_sequence();
        int unsigned n;
        logic [7:0] wd;
        no_idle = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1) == 0) begin
            wd = pick_byte();
            wd[ENABLE_BIT] = 1'b0;
            offer_item(mk(CMD_WRITE, REG_ENABLE, wd, rand_byte()));
        end
        wd = pick_byte();
        wd[3:0] = pick_rate_index(no_idle);
        offer_item(mk(CMD_WRITE, REG_RATE, wd, rand_byte()));
        n = $urandom_range(1, 5);
        repeat (n) random_write(no_idle);
        if ($urandom_range(0, 7) != 0) begin
            wd = pick_byte();
            wd[ENABLE_BIT] = 1'b1;
            offer_item(mk(CMD_WRITE, REG_ENABLE, wd, rand_byte()));
        end
        if ($urandom_range(0, 3) == 0)
            offer_item(mk(CMD_STATUS, 3'($urandom), rand_byte(), rand_byte()));
        play_back($urandom_range(4, 24));
    endtask

    // result side: random stalls per result, one long hold-off on request
    initial begin
        int unsigned gap;
        wait (aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            if (gap != 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // compare every result transfer with the oldest predicted status
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result transfer: req %b addr %h level %0d %s %b %s %b",
                             m_data.fetch_request, m_data.fetch_address, m_data.level,
                             "active", m_data.channel_active, "irq", m_data.irq_pending);
            end else begin
                want = pending_status.pop_front();
                if (m_data.fetch_request !== want.fetch_request
                        || m_data.fetch_address !== want.fetch_address
                        || m_data.level !== want.level
                        || m_data.channel_active !== want.channel_active
                        || m_data.irq_pending !== want.irq_pending) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("result %0d mismatch, expected req %b addr %h level %0d %s",
                                 results_checked, want.fetch_request, want.fetch_address,
                                 want.level, "");
                        $display("    expected active %b irq %b",
                                 want.channel_active, want.irq_pending);
                        $display("    got req %b addr %h level %0d active %b irq %b",
                                 m_data.fetch_request, m_data.fetch_address, m_data.level,
                                 m_data.channel_active, m_data.irq_pending);
                    end
                end
            end
        end
    end

    // watchdog: a hang on either side, or a run far beyond its expected length
    always @(posedge aclk) begin
        cycle_count++;
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT || cycle_count > RUN_CYCLE_CAP) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("FAIL delta_modulation_sample_channel");
            $finish;
        end
    end

    initial begin
        directed_row_t row;
        int unsigned k;

        // after reset nothing moves: status, disabled ticks, stray byte, dead selects
        directed_rows.push_back('{mk(CMD_STATUS, 3'd0, 8'h00, 8'h00), 1, 1'b1, IDLE_STATUS});
        directed_rows.push_back('{mk(CMD_TICK, 3'd7, 8'hFF, 8'hFF), 3, 1'b1, IDLE_STATUS});
        directed_rows.push_back('{mk(CMD_DELIVER, 3'd0, 8'h00, 8'hFF), 1, 1'b1, IDLE_STATUS});
        directed_rows.push_back('{mk(CMD_WRITE, REG_SPARE_FIRST, 8'hFF, 8'h00), 1, 1'b1,
                                  IDLE_STATUS});
        directed_rows.push_back('{mk(CMD_WRITE, REG_SPARE_LAST, 8'hAA, 8'h55), 1, 1'b1,
                                  IDLE_STATUS});
        // direct level at the top, upper bit of the byte dropped
        directed_rows.push_back('{mk(CMD_WRITE, REG_LEVEL, 8'hFF, 8'h00), 1, 1'b1,
                                  TOP_LEVEL_STATUS});
        // fastest rate with irq, top address, 17 bytes, then go
        directed_rows.push_back('{mk(CMD_WRITE, REG_RATE, 8'h8F, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_ADDR, 8'hFF, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_LENGTH, 8'h01, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_ENABLE, 8'h10, 8'h00), 1, 1'b0, '0});
        // first expiry asks for a byte, the next finds the fetch still outstanding
        directed_rows.push_back('{mk(CMD_TICK, 3'd0, 8'h00, 8'h00), 55, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_TICK, 3'd0, 8'h00, 8'h00), 55, 1'b0, '0});
        // all ones at the top level: every up step is held
        directed_rows.push_back('{mk(CMD_DELIVER, 3'd0, 8'h00, 8'hFF), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_TICK, 3'd0, 8'h00, 8'h00), 495, 1'b0, '0});
        // all zeros just above the floor: down steps are held
        directed_rows.push_back('{mk(CMD_DELIVER, 3'd0, 8'h00, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_LEVEL, 8'h01, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_TICK, 3'd0, 8'h00, 8'h00), 495, 1'b0, '0});
        // shortest sample in loop mode from the bottom of the sample window
        directed_rows.push_back('{mk(CMD_WRITE, REG_LENGTH, 8'h00, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_ENABLE, 8'h00, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_RATE, 8'h4F, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_ADDR, 8'h00, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_ENABLE, 8'h10, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_TICK, 3'd0, 8'h00, 8'h00), 55, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_WRITE, REG_RATE, 8'h00, 8'h00), 1, 1'b0, '0});
        directed_rows.push_back('{mk(CMD_STATUS, 3'd7, 8'hFF, 8'hFF), 1, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            for (k = 0; k < row.repeats; k++) offer_item(row.item, row.typed, row.want);
        end

        // random playback up to the item budget; the first sequence runs into a long
        // result-side hold-off
        events_done = 0;
        hold_off_pending = 1'b1;
        while (items_sent < ITEM_TARGET) play_sequence();
        no_idle = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d transfers in, %0d status words checked, %0d mismatches",
                 items_sent, results_checked, mismatches);
        $display("%0d random items beyond plain countdown, %0d sample fetches, %s %s",
                 events_done, fetches_seen, "address wrap",
                 wrapped ? "reached" : "not reached");
        $display("%0d level steps held at a limit", limit_holds);
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("PASS delta_modulation_sample_channel");
        end else begin
            $display("FAIL delta_modulation_sample_channel");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/dmsc_pkg.sv
sv/dmsc_core.sv
sv/delta_modulation_sample_channel.sv
tb/delta_modulation_sample_channel_tb.sv
